// ===== hdl/pscf_pkg.sv =====
// Shared types, codes and the CRC-16 byte update for the packet serial CRC framer.
// Used by pscf_framer, pscf_out_queue and packet_serial_crc_framer; depends on nothing.
package pscf_pkg;

  // One input word: what to do, and the command and data bytes that go with it.
  typedef struct packed {
    logic [2:0] action;
    logic [7:0] command_code;
    logic [7:0] data_byte;
  } in_item_t;

  // One result word: a line byte or a check status.
  typedef struct packed {
    logic       out_kind;
    logic [7:0] out_byte;
    logic [2:0] status;
    logic       last;
  } out_item_t;

  // Up to two result words produced by one input word.
  typedef struct packed {
    logic [1:0] count;
    out_item_t  first;
    out_item_t  second;
  } emit_t;

  // Frame progress.
  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_TX   = 2'd1,
    MODE_RX   = 2'd2,
    MODE_ACK  = 2'd3
  } mode_t;

  // Action codes.
  localparam logic [2:0] ACT_BEGIN_TX   = 3'd0;
  localparam logic [2:0] ACT_TX_PAYLOAD = 3'd1;
  localparam logic [2:0] ACT_END_TX     = 3'd2;
  localparam logic [2:0] ACT_BEGIN_RX   = 3'd3;
  localparam logic [2:0] ACT_RX_BYTE    = 3'd4;
  localparam logic [2:0] ACT_END_RX     = 3'd5;
  localparam logic [2:0] ACT_ACK_BYTE   = 3'd6;

  // Status codes.
  localparam logic [2:0] ST_OK              = 3'd0;
  localparam logic [2:0] ST_CRC_MISMATCH    = 3'd1;
  localparam logic [2:0] ST_TOO_SHORT       = 3'd2;
  localparam logic [2:0] ST_ACK_WRONG       = 3'd3;
  localparam logic [2:0] ST_OUT_OF_SEQUENCE = 3'd4;

  // Result kinds.
  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // CRC and protocol constants.
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_MSB  = 16'h8000;
  localparam logic [7:0]  ACK_GOOD = 8'hFF;
  localparam logic [7:0]  ADDR_RESET = 8'd128;

  // Output queue depth and the fill level that still leaves room for two words.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_ROOM_LEVEL = QUEUE_DEPTH - 2;

  // CRC-16, MSB first, one byte unrolled over eight bit steps.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_MSB) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  // CRC after the reset address byte, so a frame start needs only one byte update.
  localparam logic [15:0] ADDR_SEED_RESET = crc16_byte(16'h0000, ADDR_RESET);

  function automatic out_item_t make_byte(input logic [7:0] b, input logic last);
    out_item_t r;
    r.out_kind = KIND_BYTE;
    r.out_byte = b;
    r.status   = ST_OK;
    r.last     = last;
    return r;
  endfunction

  function automatic out_item_t make_status(input logic [2:0] st);
    out_item_t r;
    r.out_kind = KIND_STATUS;
    r.out_byte = 8'h00;
    r.status   = st;
    r.last     = 1'b1;
    return r;
  endfunction

endpackage

// ===== hdl/packet_serial_crc_framer.sv =====
// Top level of the packet serial CRC framer: input register, framer and result queue.
// Depends on pscf_pkg, pscf_framer and pscf_out_queue.

// The framer takes one command word per cycle while the queue has room and produces
// the line bytes and check status words of CRC-16 (polynomial 0x1021, zero start, MSB
// first) protected frames. A word is processed in an input register; its results go
// to a four-word queue ahead of the result port. Words with zero or one result are
// taken at one per cycle while results drain; the single result port gives one word
// per cycle while read, so frame starts and ends, two bytes each, are paced by it. A
// held word moves on only if the queue has room for a pair, so the input side never
// waits on a combinational path from result_ready. Write the device address through
// cfg_we/cfg_wdata only while no frame is in flight; the block does not enforce it.
module packet_serial_crc_framer (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata,
  input  logic                item_valid,
  output logic                item_ready,
  input  pscf_pkg::in_item_t  item,
  output logic                result_valid,
  input  logic                result_ready,
  output pscf_pkg::out_item_t result
);

  pscf_pkg::in_item_t held_item;
  logic               held_valid;
  logic               room;
  logic               fire;
  logic [1:0]         push_count;
  pscf_pkg::emit_t    emit;

  assign fire       = held_valid && room;
  assign item_ready = !held_valid || room;
  assign push_count = fire ? emit.count : 2'd0;

  // Input register: takes a new word when it is empty or the held one moves on this cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (item_valid && item_ready) begin
      held_valid <= 1'b1;
    end else if (fire) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      held_item <= item;
    end
  end

  // Frame state and result generation.
  pscf_framer u_framer (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .item      (held_item),
    .emit      (emit)
  );

  // Result queue in front of the output port.
  pscf_out_queue u_out_queue (
    .clk          (clk),
    .rst          (rst),
    .push_count   (push_count),
    .push_first   (emit.first),
    .push_second  (emit.second),
    .room         (room),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// ===== hdl/pscf_framer.sv =====
// Frame state, running CRC and receive hold; turns one input word into up to two results.
// Depends on pscf_pkg.
module pscf_framer (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata,
  input  logic               fire,
  input  pscf_pkg::in_item_t item,
  output pscf_pkg::emit_t    emit
);

  logic [7:0]      device_address;
  logic [15:0]     addr_seed;
  logic [15:0]     crc_accum, crc_accum_next;
  logic [15:0]     held_bytes, held_bytes_next;
  logic [1:0]      held_count, held_count_next;
  pscf_pkg::mode_t mode, mode_next;

  // Address register, with the CRC of the address byte kept alongside it.
  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= pscf_pkg::ADDR_RESET;
      addr_seed      <= pscf_pkg::ADDR_SEED_RESET;
    end else if (cfg_we) begin
      device_address <= cfg_wdata;
      addr_seed      <= pscf_pkg::crc16_byte(16'h0000, cfg_wdata);
    end
  end

  // Frame state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= pscf_pkg::MODE_IDLE;
      crc_accum  <= 16'h0000;
      held_bytes <= 16'h0000;
      held_count <= 2'd0;
    end else if (fire) begin
      mode       <= mode_next;
      crc_accum  <= crc_accum_next;
      held_bytes <= held_bytes_next;
      held_count <= held_count_next;
    end
  end

  // Next state and results for the word in the input register.
  always_comb begin
    mode_next       = mode;
    crc_accum_next  = crc_accum;
    held_bytes_next = held_bytes;
    held_count_next = held_count;
    emit.count      = 2'd0;
    emit.first      = pscf_pkg::make_status(pscf_pkg::ST_OK);
    emit.second     = pscf_pkg::make_status(pscf_pkg::ST_OK);
    case (item.action)
      pscf_pkg::ACT_BEGIN_TX, pscf_pkg::ACT_BEGIN_RX: begin
        crc_accum_next  = pscf_pkg::crc16_byte(addr_seed, item.command_code);
        held_bytes_next = 16'h0000;
        held_count_next = 2'd0;
        mode_next       = (item.action == pscf_pkg::ACT_BEGIN_TX) ? pscf_pkg::MODE_TX
                                                                   : pscf_pkg::MODE_RX;
        emit.count      = 2'd2;
        emit.first      = pscf_pkg::make_byte(device_address, 1'b0);
        emit.second     = pscf_pkg::make_byte(item.command_code, 1'b1);
      end
      pscf_pkg::ACT_TX_PAYLOAD: begin
        emit.count = 2'd1;
        if (mode != pscf_pkg::MODE_TX) begin
          emit.first = pscf_pkg::make_status(pscf_pkg::ST_OUT_OF_SEQUENCE);
        end else begin
          crc_accum_next = pscf_pkg::crc16_byte(crc_accum, item.data_byte);
          emit.first     = pscf_pkg::make_byte(item.data_byte, 1'b1);
        end
      end
      pscf_pkg::ACT_END_TX: begin
        if (mode != pscf_pkg::MODE_TX) begin
          emit.count = 2'd1;
          emit.first = pscf_pkg::make_status(pscf_pkg::ST_OUT_OF_SEQUENCE);
        end else begin
          mode_next   = pscf_pkg::MODE_ACK;
          emit.count  = 2'd2;
          emit.first  = pscf_pkg::make_byte(crc_accum[15:8], 1'b0);
          emit.second = pscf_pkg::make_byte(crc_accum[7:0], 1'b1);
        end
      end
      pscf_pkg::ACT_RX_BYTE: begin
        if (mode != pscf_pkg::MODE_RX) begin
          emit.count = 2'd1;
          emit.first = pscf_pkg::make_status(pscf_pkg::ST_OUT_OF_SEQUENCE);
        end else begin
          // The older held byte joins the sum only once the hold is full.
          if (held_count == 2'd2) begin
            crc_accum_next = pscf_pkg::crc16_byte(crc_accum, held_bytes[15:8]);
          end else begin
            held_count_next = held_count + 2'd1;
          end
          held_bytes_next = {held_bytes[7:0], item.data_byte};
        end
      end
      pscf_pkg::ACT_END_RX: begin
        emit.count = 2'd1;
        if (mode != pscf_pkg::MODE_RX) begin
          emit.first = pscf_pkg::make_status(pscf_pkg::ST_OUT_OF_SEQUENCE);
        end else begin
          mode_next = pscf_pkg::MODE_IDLE;
          if (held_count != 2'd2) begin
            emit.first = pscf_pkg::make_status(pscf_pkg::ST_TOO_SHORT);
          end else if (held_bytes == crc_accum) begin
            emit.first = pscf_pkg::make_status(pscf_pkg::ST_OK);
          end else begin
            emit.first = pscf_pkg::make_status(pscf_pkg::ST_CRC_MISMATCH);
          end
        end
      end
      pscf_pkg::ACT_ACK_BYTE: begin
        emit.count = 2'd1;
        if (mode != pscf_pkg::MODE_ACK) begin
          emit.first = pscf_pkg::make_status(pscf_pkg::ST_OUT_OF_SEQUENCE);
        end else begin
          mode_next  = pscf_pkg::MODE_IDLE;
          emit.first = pscf_pkg::make_status((item.data_byte == pscf_pkg::ACK_GOOD)
                                             ? pscf_pkg::ST_OK : pscf_pkg::ST_ACK_WRONG);
        end
      end
      default: begin
        // Unused action code: no result and no change.
        emit.count = 2'd0;
      end
    endcase
  end

`ifndef SYNTHESIS
  // The hold never counts beyond two bytes.
  a_held_count_range: assert property (@(posedge clk) disable iff (rst)
    held_count != 2'd3)
    else $error("held_count out of range");

  // A transmit start always leaves the framer transmitting.
  a_begin_tx_mode: assert property (@(posedge clk) disable iff (rst)
    fire && item.action == pscf_pkg::ACT_BEGIN_TX |=> mode == pscf_pkg::MODE_TX)
    else $error("begin_tx did not enter transmit mode");

  // Of a pair of results only the second is marked last.
  a_pair_last: assert property (@(posedge clk) disable iff (rst)
    emit.count == 2'd2 |-> emit.second.last && !emit.first.last)
    else $error("result pair has wrong last marks");
`endif

endmodule

// ===== hdl/pscf_out_queue.sv =====
// Four-word result queue that takes up to two words a cycle while room is high and
// gives one a cycle while result_ready is high. Depends on pscf_pkg.
module pscf_out_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic [1:0]          push_count,
  input  pscf_pkg::out_item_t push_first,
  input  pscf_pkg::out_item_t push_second,
  output logic                room,
  output logic                result_valid,
  input  logic                result_ready,
  output pscf_pkg::out_item_t result
);

  localparam int unsigned PtrW = $clog2(pscf_pkg::QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(pscf_pkg::QUEUE_DEPTH + 1);

  pscf_pkg::out_item_t entries [pscf_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0]     wr_ptr, rd_ptr;
  logic [CntW-1:0]     count, count_next;
  logic                pop;
  logic [PtrW-1:0]     wr_ptr_second;

  assign pop           = result_valid && result_ready;
  assign wr_ptr_second = wr_ptr + PtrW'(1);
  assign count_next    = count + CntW'(push_count) - CntW'(pop);

  // Room for a full pair, judged on the registered fill level alone.
  assign room         = count <= CntW'(pscf_pkg::QUEUE_ROOM_LEVEL);
  assign result_valid = count != CntW'(0);
  assign result       = entries[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PtrW'(push_count);
      rd_ptr <= rd_ptr + PtrW'(pop);
      count  <= count_next;
    end
  end

  // Word storage; the second word of a pair goes in the slot after the first.
  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      entries[wr_ptr] <= push_first;
    end
    if (push_count == 2'd2) begin
      entries[wr_ptr_second] <= push_second;
    end
  end

`ifndef SYNTHESIS
  // The fill level never passes the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(pscf_pkg::QUEUE_DEPTH))
    else $error("result queue overfilled");

  // Words are only pushed while a full pair still fits.
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push_count != 2'd0 |-> room)
    else $error("push without room");

  // A pop with nothing pushed lowers the level by exactly one.
  a_pop_level: assert property (@(posedge clk) disable iff (rst)
    pop && push_count == 2'd0 |=> count == $past(count) - CntW'(1))
    else $error("fill level wrong after pop");
`endif

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for packet_serial_crc_framer: directed, address and random tests.
// It predicts every result word from its own CRC-16 framer model and checks the words in order.
// Depends on pscf_pkg and the packet_serial_crc_framer RTL.
`timescale 1ns / 100ps

module testbench;

  // Cycles allowed after the last expected word for words still inside the block.
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_ITEMS  = 1900;
  // The one action code that the block ignores.
  localparam logic [2:0] ACT_UNUSED = 3'd7;

  logic      clk;
  logic      rst;
  logic      cfg_we;
  logic [7:0] cfg_wdata;
  logic      item_valid;
  logic      item_ready;
  pscf_pkg::in_item_t  item_word;
  logic      result_valid;
  logic      result_ready;
  pscf_pkg::out_item_t result_word;

  // Prediction state: address register and frame progress.
  logic [7:0]  dev_addr;
  logic [15:0] crc_sum;
  logic [15:0] held_pair;
  logic [1:0]  held_num;
  pscf_pkg::mode_t frame_mode;

  // Result words still owed by the block, oldest first.
  pscf_pkg::out_item_t due_words[$];

  int errors;
  int sent_count;
  int hold_off;
  bit quiet;

  packet_serial_crc_framer DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item_word),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result_word)
  );

  // Free-running clock with a 2 ns period.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // CRC-16, polynomial 0x1021, fed one data bit at a time, most significant bit first.
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ b[i];
      r  = {r[14:0], 1'b0} ^ (fb ? pscf_pkg::CRC_POLY : 16'h0000);
    end
    return r;
  endfunction

  task automatic owe_byte(input logic [7:0] b, input logic is_last);
    pscf_pkg::out_item_t w;
    w.out_kind = pscf_pkg::KIND_BYTE;
    w.out_byte = b;
    w.status   = pscf_pkg::ST_OK;
    w.last     = is_last;
    due_words.push_back(w);
  endtask

  task automatic owe_status(input logic [2:0] st);
    pscf_pkg::out_item_t w;
    w.out_kind = pscf_pkg::KIND_STATUS;
    w.out_byte = 8'h00;
    w.status   = st;
    w.last     = 1'b1;
    due_words.push_back(w);
  endtask

  // Advances the framer prediction by one accepted word and records the words it owes.
  task automatic advance_framer(input pscf_pkg::in_item_t w);
    case (w.action)
      pscf_pkg::ACT_BEGIN_TX, pscf_pkg::ACT_BEGIN_RX: begin
        crc_sum    = crc_step(crc_step(16'h0000, dev_addr), w.command_code);
        held_pair  = 16'h0000;
        held_num   = 2'd0;
        frame_mode = (w.action == pscf_pkg::ACT_BEGIN_TX) ? pscf_pkg::MODE_TX
                                                          : pscf_pkg::MODE_RX;
        owe_byte(dev_addr, 1'b0);
        owe_byte(w.command_code, 1'b1);
      end
      pscf_pkg::ACT_TX_PAYLOAD: begin
        if (frame_mode != pscf_pkg::MODE_TX) begin
          owe_status(pscf_pkg::ST_OUT_OF_SEQUENCE);
        end else begin
          crc_sum = crc_step(crc_sum, w.data_byte);
          owe_byte(w.data_byte, 1'b1);
        end
      end
      pscf_pkg::ACT_END_TX: begin
        if (frame_mode != pscf_pkg::MODE_TX) begin
          owe_status(pscf_pkg::ST_OUT_OF_SEQUENCE);
        end else begin
          owe_byte(crc_sum[15:8], 1'b0);
          owe_byte(crc_sum[7:0], 1'b1);
          frame_mode = pscf_pkg::MODE_ACK;
        end
      end
      pscf_pkg::ACT_RX_BYTE: begin
        if (frame_mode != pscf_pkg::MODE_RX) begin
          owe_status(pscf_pkg::ST_OUT_OF_SEQUENCE);
        end else begin
          // The byte pushed out of a full hold is payload, so it joins the sum.
          if (held_num == 2'd2) begin
            crc_sum = crc_step(crc_sum, held_pair[15:8]);
          end else begin
            held_num = held_num + 2'd1;
          end
          held_pair = {held_pair[7:0], w.data_byte};
        end
      end
      pscf_pkg::ACT_END_RX: begin
        if (frame_mode != pscf_pkg::MODE_RX) begin
          owe_status(pscf_pkg::ST_OUT_OF_SEQUENCE);
        end else begin
          frame_mode = pscf_pkg::MODE_IDLE;
          if (held_num != 2'd2) begin
            owe_status(pscf_pkg::ST_TOO_SHORT);
          end else begin
            owe_status((held_pair == crc_sum) ? pscf_pkg::ST_OK : pscf_pkg::ST_CRC_MISMATCH);
          end
        end
      end
      pscf_pkg::ACT_ACK_BYTE: begin
        if (frame_mode != pscf_pkg::MODE_ACK) begin
          owe_status(pscf_pkg::ST_OUT_OF_SEQUENCE);
        end else begin
          frame_mode = pscf_pkg::MODE_IDLE;
          owe_status((w.data_byte == pscf_pkg::ACK_GOOD) ? pscf_pkg::ST_OK
                                                         : pscf_pkg::ST_ACK_WRONG);
        end
      end
      default: begin
      end
    endcase
  endtask

  // Samples both channels at the rising edge: predicts accepted words, checks result words.
  always @(posedge clk) begin : check_results
    pscf_pkg::out_item_t want;
    if (rst) begin
      dev_addr   = pscf_pkg::ADDR_RESET;
      crc_sum    = 16'h0000;
      held_pair  = 16'h0000;
      held_num   = 2'd0;
      frame_mode = pscf_pkg::MODE_IDLE;
    end else begin
      if (cfg_we) begin
        dev_addr = cfg_wdata;
      end
      if (item_valid && item_ready) begin
        advance_framer(item_word);
      end
      if (result_valid && result_ready) begin
        if (due_words.size() == 0) begin
          errors++;
          $display("%0t: unexpected result word: kind %0d byte %02h status %0d last %0d",
                   $time, result_word.out_kind, result_word.out_byte,
                   result_word.status, result_word.last);
        end else begin
          want = due_words.pop_front();
          if (result_word.out_kind !== want.out_kind || result_word.out_byte !== want.out_byte ||
              result_word.status !== want.status || result_word.last !== want.last) begin
            errors++;
            $display("%0t: result mismatch: expected kind %0d byte %02h status %0d last %0d,",
                     $time, want.out_kind, want.out_byte, want.status, want.last);
            $display("%0t:   actual kind %0d byte %02h status %0d last %0d", $time,
                     result_word.out_kind, result_word.out_byte, result_word.status,
                     result_word.last);
          end
        end
        hold_off = quiet ? 0 : $urandom_range(0, 10);
      end
    end
  end

  // Result side: stalls for the drawn number of cycles after each word it takes.
  initial begin
    result_ready = 1'b0;
    hold_off     = 0;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        result_ready = 1'b0;
        hold_off--;
      end else begin
        result_ready = 1'b1;
      end
    end
  end

  // Sends one word after a random gap and returns at the edge where it is accepted.
  task automatic send_word(input logic [2:0] act, input logic [7:0] cmd, input logic [7:0] data);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 10);
    @(negedge clk);
    if (gap != 0) begin
      item_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_word.action       = act;
    item_word.command_code = cmd;
    item_word.data_byte    = data;
    item_valid             = 1'b1;
    do @(posedge clk); while (!item_ready);
    if (act != ACT_UNUSED) begin
      sent_count++;
    end
  endtask

  // Stops sending and waits until every owed word has come out.
  task automatic wait_drained();
    @(negedge clk);
    item_valid = 1'b0;
    while (due_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_address(input logic [7:0] v);
    wait_drained();
    @(negedge clk);
    cfg_wdata = v;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // Transmit frame; stage 0 stops before end_tx, stage 1 before the acknowledge.
  task automatic send_tx_frame(input logic [7:0] cmd, input int n, input logic [7:0] ack,
                               input int stage);
    send_word(pscf_pkg::ACT_BEGIN_TX, cmd, 8'($urandom_range(0, 255)));
    repeat (n) begin
      send_word(pscf_pkg::ACT_TX_PAYLOAD, 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)));
    end
    if (stage >= 1) begin
      send_word(pscf_pkg::ACT_END_TX, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    end
    if (stage >= 2) begin
      send_word(pscf_pkg::ACT_ACK_BYTE, 8'($urandom_range(0, 255)), ack);
    end
  endtask

  // Receive frame with n payload bytes, then optionally its CRC (xored with flip to corrupt it) and the end word.
  task automatic send_rx_frame(input logic [7:0] cmd, input int n, input logic [15:0] flip,
                               input bit with_crc, input bit with_end);
    logic [15:0] sum;
    logic [7:0]  b;
    sum = crc_step(crc_step(16'h0000, dev_addr), cmd);
    send_word(pscf_pkg::ACT_BEGIN_RX, cmd, 8'($urandom_range(0, 255)));
    repeat (n) begin
      b   = 8'($urandom_range(0, 255));
      sum = crc_step(sum, b);
      send_word(pscf_pkg::ACT_RX_BYTE, 8'($urandom_range(0, 255)), b);
    end
    if (with_crc) begin
      sum = sum ^ flip;
      send_word(pscf_pkg::ACT_RX_BYTE, 8'($urandom_range(0, 255)), sum[15:8]);
      send_word(pscf_pkg::ACT_RX_BYTE, 8'($urandom_range(0, 255)), sum[7:0]);
    end
    if (with_end) begin
      send_word(pscf_pkg::ACT_END_RX, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    end
  endtask

  // Field extremes, every action, sequence errors and each status at the reset address.
  task automatic test_directed();
    send_word(pscf_pkg::ACT_TX_PAYLOAD, 8'hFF, 8'hFF);
    send_word(pscf_pkg::ACT_END_TX, 8'h00, 8'h00);
    send_word(pscf_pkg::ACT_RX_BYTE, 8'hFF, 8'h00);
    send_word(pscf_pkg::ACT_END_RX, 8'h00, 8'hFF);
    send_word(pscf_pkg::ACT_ACK_BYTE, 8'hFF, 8'hFF);
    // The unused action code is ignored altogether.
    send_word(ACT_UNUSED, 8'hFF, 8'hFF);
    send_word(pscf_pkg::ACT_BEGIN_TX, 8'h00, 8'h00);
    send_word(pscf_pkg::ACT_TX_PAYLOAD, 8'h00, 8'h00);
    send_word(pscf_pkg::ACT_TX_PAYLOAD, 8'hFF, 8'hFF);
    send_word(pscf_pkg::ACT_END_TX, 8'h00, 8'h00);
    send_word(pscf_pkg::ACT_TX_PAYLOAD, 8'h55, 8'hAA);
    // A new frame abandons the pending acknowledge.
    send_word(pscf_pkg::ACT_BEGIN_RX, 8'hFF, 8'h00);
    send_word(pscf_pkg::ACT_RX_BYTE, 8'h00, 8'hFF);
    send_word(pscf_pkg::ACT_ACK_BYTE, 8'h00, 8'hFF);
    send_word(pscf_pkg::ACT_END_RX, 8'h00, 8'h00);
    send_tx_frame(8'hA5, 0, 8'h00, 2);
    send_word(pscf_pkg::ACT_BEGIN_RX, 8'h3C, 8'h00);
    send_word(pscf_pkg::ACT_END_RX, 8'h00, 8'h00);
    send_rx_frame(8'h7E, 0, 16'h0000, 1'b1, 1'b1);
    send_rx_frame(8'h81, 0, 16'h0001, 1'b1, 1'b1);
  endtask

  // Address register at both extremes, a few random values and back to its reset value.
  task automatic test_address_settings();
    logic [7:0] addrs[6];
    addrs = '{8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, pscf_pkg::ADDR_RESET};
    for (int k = 2; k < 5; k++) begin
      addrs[k] = 8'($urandom_range(0, 255));
    end
    foreach (addrs[k]) begin
      write_address(addrs[k]);
      send_tx_frame(8'($urandom_range(0, 255)), $urandom_range(0, 3), pscf_pkg::ACK_GOOD, 2);
      send_rx_frame(8'($urandom_range(0, 255)), $urandom_range(0, 3), 16'h0000, 1'b1, 1'b1);
    end
  endtask

  // Mostly well-formed frames with random content, plus broken frames and random words.
  task automatic test_random_traffic();
    int pick;
    int next_phase;
    bit drained_once;
    next_phase   = sent_count;
    drained_once = 1'b0;
    sent_count   = 0;
    next_phase   = 0;
    while (sent_count < RANDOM_ITEMS) begin
      if (sent_count >= next_phase) begin
        // New phase: fresh address, sometimes an extreme, and a new idling pattern.
        pick = $urandom_range(0, 3);
        write_address(pick == 0 ? 8'h00 : (pick == 1 ? 8'hFF : 8'($urandom_range(0, 255))));
        quiet      = ($urandom_range(0, 3) == 0);
        next_phase = sent_count + 300;
      end
      if (!drained_once && sent_count >= RANDOM_ITEMS / 2) begin
        wait_drained();
        drained_once = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        send_tx_frame(8'($urandom_range(0, 255)), $urandom_range(0, 6),
                      ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255))
                                                  : pscf_pkg::ACK_GOOD,
                      ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 1)) : 2);
      end else if (pick < 80) begin
        send_rx_frame(8'($urandom_range(0, 255)), $urandom_range(0, 6),
                      ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535)) : 16'h0000,
                      $urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_word(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)));
        end
      end
    end
  endtask

  // Run limit well beyond the slowest correct run.
  initial begin
    #1000000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_wdata  = 8'h00;
    item_valid = 1'b0;
    item_word  = '0;
    errors     = 0;
    sent_count = 0;
    quiet      = 1'b0;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_address_settings();
    test_random_traffic();
    wait_drained();

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
